/* rtl/adaptive_mean_threshold_unit_defines.svh */
// Assertion macros shared by the adaptive mean threshold RTL.
`ifndef ADAPTIVE_MEAN_THRESHOLD_UNIT_DEFINES_SVH
`define ADAPTIVE_MEAN_THRESHOLD_UNIT_DEFINES_SVH

`ifndef SYNTH
`define AMT_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("adaptive mean threshold check failed");
`define AMT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("adaptive mean threshold check failed");
`else
`define AMT_ASSERT_IMP(name, clk, rst, ante, cons)
`define AMT_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

/* rtl/amt_pkg.sv */
// Shared types and constants of the adaptive mean threshold unit.
`default_nettype none

package amt_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_RADIUS = 15;
   localparam int MAX_HEIGHT     = 4096;

   localparam int PIX_W      = 8;
   localparam int CFG_W_W    = 11;
   localparam int CFG_H_W    = 13;
   localparam int CFG_R_W    = 4;
   localparam int CFG_TAU_W  = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   localparam int Y_W    = 12;  // row index inside a frame
   localparam int SPAN_W = 5;   // window offset 0 .. 2r
   localparam int S2_W   = 10;  // window area up to 31 * 31
   localparam int SUM_W  = 18;  // window sum plus rounding term
   localparam int CMP_W  = 11;

   localparam logic [CFG_W_W-1:0]   RST_WIDTH  = 11'd640;
   localparam logic [CFG_H_W-1:0]   RST_HEIGHT = 13'd480;
   localparam logic [CFG_R_W-1:0]   RST_RADIUS = 4'd1;
   localparam logic [CFG_TAU_W-1:0] RST_TAU    = 9'd0;
   localparam logic [PIX_W-1:0]     RST_MAXV   = 8'd255;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FRAME_WIDTH   = 3'd0,
      REG_FRAME_HEIGHT  = 3'd1,
      REG_WINDOW_RADIUS = 3'd2,
      REG_TAU_OFFSET    = 3'd3,
      REG_MAX_VALUE     = 3'd4,
      REG_INVERT        = 3'd5
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DECIDE = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_DIVIDE = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] numer;
      logic [S2_W-1:0]  denom;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [SUM_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

/* rtl/adaptive_mean_threshold_unit.sv */
// Adaptive mean threshold unit: streams raster pixels and binarizes each against
// the rounded mean of the replicated-border (2r+1) x (2r+1) window centered on it.
//
// The req channel takes one beat per item: tuser[0] is the action (0 pixel,
// 1 drain) and tdata[7:0] the pixel. The rsp channel gives zero or one beat per
// item: tdata[7:0] is the thresholded value and tlast marks the last pixel of
// the frame. The result of raster pixel k comes with item k + r*W + r, so a
// frame of W*H pixels is followed by r*W + r drain beats. The csr channel writes
// the six registers by index; a write restarts the frame position.
// An item that gives no result goes through the decide state and back to idle.
// An item that gives a result also scans its window: every window pixel is
// fetched from the line store through its single read port, one per cycle, and
// the mean then goes through an 18-step divider. The next beat is taken while a
// result still waits in the rsp register; a stalled receiver holds the block only
// when a new result is ready. Reset restores the register defaults and clears the
// frame position; the line store contents are left as they are.
`default_nettype none

`include "adaptive_mean_threshold_unit_defines.svh"

module adaptive_mean_threshold_unit #(
   parameter int MAX_WIDTH  = amt_pkg::DEF_MAX_WIDTH,
   parameter int MAX_RADIUS = amt_pkg::DEF_MAX_RADIUS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output      logic                          req_tready,
   input  wire logic [7:0]                    req_tdata,   // [7:0] pixel
   input  wire logic [0:0]                    req_tuser,   // [0] action
   output      logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   output      logic [7:0]                    rsp_tdata,   // [7:0] out_value
   output      logic                          rsp_tlast,
   input  wire logic                          csr_valid,
   output      logic                          csr_ready,
   input  wire logic [amt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [amt_pkg::CSR_DATA_W-1:0] csr_data
);
   import amt_pkg::*;

   localparam int LINE_DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH + 2 * MAX_RADIUS + 1;
   localparam int A_W  = $clog2(LINE_DEPTH);
   localparam int N_W  = $clog2(MAX_HEIGHT * MAX_WIDTH + LINE_DEPTH);
   localparam int X_W  = $clog2(MAX_WIDTH);
   localparam int WE_W = $clog2(MAX_WIDTH + 1);
   localparam int CX_W = X_W + SPAN_W + 1;
   localparam int CY_W = Y_W + SPAN_W + 1;

   // Configuration registers
   logic [CFG_W_W-1:0]          width_ff, width_in;
   logic [CFG_H_W-1:0]          height_ff, height_in;
   logic [CFG_R_W-1:0]          radius_ff, radius_in;
   logic signed [CFG_TAU_W-1:0] tau_ff, tau_in;
   logic [PIX_W-1:0]            maxv_ff, maxv_in;
   logic                        invert_ff, invert_in;
   logic                        csr_hit;

   // Derived frame geometry
   logic [WE_W-1:0]    w_eff;
   logic [CFG_H_W-1:0] h_eff;
   logic [CFG_R_W-1:0] r_eff;
   logic [SPAN_W-1:0]  span_max;
   logic [S2_W-1:0]    span;
   logic [N_W-1:0]     total_ff, total_in;
   logic [N_W-1:0]     delay_ff, delay_in;
   logic [S2_W-1:0]    s2_ff, s2_in;
   logic [S2_W-1:0]    half_ff, half_in;

   // Sequencer and position state
   state_type        state_ff, state_in;
   logic [N_W-1:0]   n_ff, n_in;
   logic [A_W-1:0]   wp_ff, wp_in;
   logic [X_W-1:0]   ox_ff, ox_in;
   logic [Y_W-1:0]   oy_ff, oy_in;
   logic             act_ff, act_in;
   logic [PIX_W-1:0] pix_ff, pix_in;
   logic [N_W-1:0]   cur_n_ff, cur_n_in;
   logic [A_W-1:0]   cur_wp_ff, cur_wp_in;
   logic             last_ff, last_in;
   logic             in_frame;

   // Window scan
   logic [SPAN_W-1:0] i_ff, i_in;
   logic [SPAN_W-1:0] j_ff, j_in;
   logic              issue_ff, issue_in;
   logic signed [CY_W-1:0] ycoord;
   logic signed [CX_W-1:0] xcoord;
   logic [Y_W-1:0]    ycl;
   logic [X_W-1:0]    xcl;

   // Address pipeline
   logic             s1_v_ff, s1_c_ff;
   logic [Y_W-1:0]   s1_y_ff;
   logic [X_W-1:0]   s1_x_ff;
   logic             s2_v_ff, s2_c_ff;
   logic [N_W-1:0]   s2_prod_ff;
   logic [X_W-1:0]   s2_x_ff;
   logic             s3_v_ff, s3_c_ff;
   logic [A_W-1:0]   s3_diff_ff;
   logic             s4_v_ff, s4_c_ff;
   logic             pipe_busy;
   logic [A_W-1:0]   rd_addr;
   logic [PIX_W-1:0] rd_data;

   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [PIX_W-1:0] centre_ff, centre_in;

   // Divider and output
   div_req_type      div_req;
   div_rsp_type      div_rsp;
   logic [PIX_W-1:0] mean;
   logic             above;
   logic [PIX_W-1:0] gt_level, lt_level;
   logic             emit_load;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] rsp_value_ff, rsp_value_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             wr_en;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_hit    = csr_valid && (csr_index <= REG_INVERT);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      radius_in = radius_ff;
      tau_in    = tau_ff;
      maxv_in   = maxv_ff;
      invert_in = invert_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_FRAME_WIDTH:   width_in  = csr_data[CFG_W_W-1:0];
            REG_FRAME_HEIGHT:  height_in = csr_data[CFG_H_W-1:0];
            REG_WINDOW_RADIUS: radius_in = csr_data[CFG_R_W-1:0];
            REG_TAU_OFFSET:    tau_in    = csr_data[CFG_TAU_W-1:0];
            REG_MAX_VALUE:     maxv_in   = csr_data[PIX_W-1:0];
            REG_INVERT:        invert_in = csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         w_eff = WE_W'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         w_eff = WE_W'(MAX_WIDTH);
      end else begin
         w_eff = WE_W'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = CFG_H_W'(1);
      end else if (int'(height_ff) > MAX_HEIGHT) begin
         h_eff = CFG_H_W'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
      if (int'(radius_ff) > MAX_RADIUS) begin
         r_eff = CFG_R_W'(MAX_RADIUS);
      end else begin
         r_eff = radius_ff;
      end
      span_max = {r_eff, 1'b0};
      span     = S2_W'({r_eff, 1'b1});
      total_in = N_W'(w_eff) * N_W'(h_eff);
      delay_in = N_W'(r_eff) * N_W'(w_eff) + N_W'(r_eff);
      s2_in    = span * span;
      half_in  = s2_in >> 1;
   end

   // Window coordinates with the border replicated.
   always_comb begin
      ycoord = signed'(CY_W'(oy_ff)) + signed'(CY_W'(i_ff)) - signed'(CY_W'(r_eff));
      xcoord = signed'(CX_W'(ox_ff)) + signed'(CX_W'(j_ff)) - signed'(CX_W'(r_eff));
      if (ycoord < 0) begin
         ycl = '0;
      end else if (ycoord >= signed'(CY_W'(h_eff))) begin
         ycl = Y_W'(h_eff - 1'b1);
      end else begin
         ycl = ycoord[Y_W-1:0];
      end
      if (xcoord < 0) begin
         xcl = '0;
      end else if (xcoord >= signed'(CX_W'(w_eff))) begin
         xcl = X_W'(w_eff - 1'b1);
      end else begin
         xcl = xcoord[X_W-1:0];
      end
   end

   // The ring slot of a window pixel lies diff entries behind the current slot.
   always_comb begin
      if (cur_wp_ff >= s3_diff_ff) begin
         rd_addr = cur_wp_ff - s3_diff_ff;
      end else begin
         rd_addr = A_W'((A_W + 1)'(cur_wp_ff) + (A_W + 1)'(LINE_DEPTH)
                        - (A_W + 1)'(s3_diff_ff));
      end
   end

   assign pipe_busy = s1_v_ff || s2_v_ff || s3_v_ff || s4_v_ff;
   assign in_frame  = (n_ff < total_ff);

   always_comb begin
      mean     = div_rsp.quotient[PIX_W-1:0];
      above    = (signed'(CMP_W'(centre_ff)) + CMP_W'(tau_ff)) > signed'(CMP_W'(mean));
      gt_level = invert_ff ? '0 : maxv_ff;
      lt_level = maxv_ff - gt_level;
   end

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      wp_in        = wp_ff;
      ox_in        = ox_ff;
      oy_in        = oy_ff;
      act_in       = act_ff;
      pix_in       = pix_ff;
      cur_n_in     = cur_n_ff;
      cur_wp_in    = cur_wp_ff;
      last_in      = last_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      issue_in     = issue_ff;
      sum_in       = sum_ff;
      centre_in    = centre_ff;
      wr_en        = 1'b0;
      emit_load    = 1'b0;
      div_req      = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;

      if (s4_v_ff) begin
         sum_in = sum_ff + SUM_W'(rd_data);
         if (s4_c_ff) begin
            centre_in = rd_data;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               act_in   = req_tuser[0];
               pix_in   = req_tdata;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (in_frame && act_ff) begin
               // A drain beat inside the frame is dropped without a trace.
               state_in = ST_IDLE;
            end else begin
               wr_en     = in_frame;
               n_in      = n_ff + 1'b1;
               wp_in     = (int'(wp_ff) == LINE_DEPTH - 1) ? '0 : wp_ff + 1'b1;
               cur_n_in  = n_ff;
               cur_wp_in = wp_ff;
               last_in   = (n_ff == total_ff - 1'b1 + delay_ff);
               if (n_ff < delay_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  i_in     = '0;
                  j_in     = '0;
                  issue_in = 1'b1;
                  sum_in   = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (issue_ff) begin
               if (j_ff == span_max) begin
                  j_in = '0;
                  if (i_ff == span_max) begin
                     issue_in = 1'b0;
                  end else begin
                     i_in = i_ff + 1'b1;
                  end
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end else if (!pipe_busy) begin
               div_req.start = 1'b1;
               div_req.numer = sum_ff + SUM_W'(half_ff);
               div_req.denom = s2_ff;
               state_in      = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               emit_load    = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_value_in = above ? gt_level : lt_level;
               rsp_last_in  = last_ff;
               if (int'(ox_ff) + 1 >= int'(w_eff)) begin
                  ox_in = '0;
                  oy_in = oy_ff + 1'b1;
               end else begin
                  ox_in = ox_ff + 1'b1;
               end
               if (last_ff) begin
                  n_in  = '0;
                  wp_in = '0;
                  ox_in = '0;
                  oy_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // Any register write restarts the frame position.
      if (csr_hit) begin
         n_in  = '0;
         wp_in = '0;
         ox_in = '0;
         oy_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= RST_WIDTH;
         height_ff    <= RST_HEIGHT;
         radius_ff    <= RST_RADIUS;
         tau_ff       <= RST_TAU;
         maxv_ff      <= RST_MAXV;
         invert_ff    <= 1'b0;
         state_ff     <= ST_IDLE;
         n_ff         <= '0;
         wp_ff        <= '0;
         ox_ff        <= '0;
         oy_ff        <= '0;
         issue_ff     <= 1'b0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         s4_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         radius_ff    <= radius_in;
         tau_ff       <= tau_in;
         maxv_ff      <= maxv_in;
         invert_ff    <= invert_in;
         state_ff     <= state_in;
         n_ff         <= n_in;
         wp_ff        <= wp_in;
         ox_ff        <= ox_in;
         oy_ff        <= oy_in;
         issue_ff     <= issue_in;
         s1_v_ff      <= (state_ff == ST_SCAN) && issue_ff;
         s2_v_ff      <= s1_v_ff;
         s3_v_ff      <= s2_v_ff;
         s4_v_ff      <= s3_v_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
      total_ff     <= total_in;
      delay_ff     <= delay_in;
      s2_ff        <= s2_in;
      half_ff      <= half_in;
      act_ff       <= act_in;
      pix_ff       <= pix_in;
      cur_n_ff     <= cur_n_in;
      cur_wp_ff    <= cur_wp_in;
      last_ff      <= last_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      s1_y_ff      <= ycl;
      s1_x_ff      <= xcl;
      s1_c_ff      <= (i_ff == SPAN_W'(r_eff)) && (j_ff == SPAN_W'(r_eff));
      s2_prod_ff   <= N_W'(s1_y_ff) * N_W'(w_eff);
      s2_x_ff      <= s1_x_ff;
      s2_c_ff      <= s1_c_ff;
      s3_diff_ff   <= A_W'(cur_n_ff - (s2_prod_ff + N_W'(s2_x_ff)));
      s3_c_ff      <= s2_c_ff;
      s4_c_ff      <= s3_c_ff;
      sum_ff       <= sum_in;
      centre_ff    <= centre_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   amt_line_store #(
      .DEPTH  (LINE_DEPTH),
      .ADDR_W (A_W)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (pix_ff),
      .rd_en   (s3_v_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   amt_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tlast  = rsp_last_ff;

   `AMT_ASSERT_IMP(a_div_after_drain, clock, reset, div_req.start, !pipe_busy)
   `AMT_ASSERT_NEXT(a_emit_waits, clock, reset, (state_ff == ST_EMIT) && rsp_valid_ff && !rsp_tready, state_ff == ST_EMIT)
   `AMT_ASSERT_NEXT(a_last_clears, clock, reset, emit_load && last_ff, (n_ff == '0) && (wp_ff == '0))

endmodule

`default_nettype wire

/* rtl/amt_line_store.sv */
// Pixel line store: one write port and one read port with registered read data.
`default_nettype none

module amt_line_store #(
   parameter int DEPTH  = 31775,
   parameter int ADDR_W = 15
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [ADDR_W-1:0]        wr_addr,
   input  wire logic [amt_pkg::PIX_W-1:0] wr_data,
   input  wire logic                     rd_en,
   input  wire logic [ADDR_W-1:0]        rd_addr,
   output      logic [amt_pkg::PIX_W-1:0] rd_data
);
   import amt_pkg::*;

   logic [PIX_W-1:0] mem_ff [DEPTH];
   logic [PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/amt_divider.sv */
// Restoring divider that forms the rounded window mean, one quotient bit per cycle.
`default_nettype none

module amt_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire amt_pkg::div_req_type req,
   output      amt_pkg::div_rsp_type rsp
);
   import amt_pkg::*;

   localparam int CNT_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0] quot_ff, quot_in;
   logic [S2_W:0]    rem_ff, rem_in;
   logic [S2_W-1:0]  den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [S2_W:0]    trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[S2_W-1:0], quot_ff[SUM_W-1]};
      if (req.start) begin
         quot_in = req.numer;
         rem_in  = '0;
         den_in  = req.denom;
         cnt_in  = CNT_W'(SUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in  = trial - {1'b0, den_ff};
            quot_in = {quot_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[SUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quot_ff;

endmodule

`default_nettype wire
